// File: rtl/core/sobel_gradient_magnitude_assert.svh
// ----------------------------------------------------------------------------
// sobel gradient magnitude assertion macros
// concurrent assertion helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_ASSERT_SVH

`ifndef SYNTHESIS
`define SGM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sgm assertion failed");
`define SGM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sgm assertion failed");
`else
`define SGM_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define SGM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: rtl/core/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// shared types and constants of the sobel gradient magnitude block
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int GRAD_W      = 11;
    localparam int MAG_W       = 11;
    localparam int CFG_W_W     = 11;
    localparam int CFG_H_W     = 13;

    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam int SQ_W        = 2 * (GRAD_W - 1);
    localparam int RAD_W       = 2 * MAG_W;
    localparam int SQRT_STEPS  = MAG_W;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

    typedef struct packed {
        logic [COL_W-1:0] w_last;
        logic [ROW_W-1:0] h_last;
        logic             restart;
    } sgm_cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } sgm_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } sgm_qstat_t;

endpackage

// File: rtl/core/sgm_front.sv
// ----------------------------------------------------------------------------
// sgm_front
// pixel intake: position counters, line stores, 3x3 window and gradients
// ----------------------------------------------------------------------------
module sgm_front
    import sgm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sgm_cfg_t         cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] pixel
    input  sgm_qstat_t       qstat,
    output logic             push,
    output sgm_entry_t       push_entry
);

    typedef enum logic {F_IDLE, F_PROC} fstate_t;

    fstate_t            state_reg;
    logic [COL_W-1:0]   col_reg, c_reg;
    logic [ROW_W-1:0]   row_reg, r_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   top_reg, mid_reg;
    logic [PIX_W-1:0]   win_reg [6];

    logic [PIX_W-1:0]   upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_mem [MAX_WIDTH];

    logic               accept;
    logic               border;
    logic [PIX_W-1:0]   v;
    logic [PIX_W+1:0]   gx_pos, gx_neg, gy_pos, gy_neg;
    logic               produce;

    assign s_tready = (state_reg == F_IDLE) && !qstat.full;
    assign accept   = s_tvalid && s_tready;

    assign border = (r_reg == '0) || (r_reg == cfg.h_last) ||
                    (c_reg == '0) || (c_reg == cfg.w_last);
    assign v      = border ? '0 : pix_reg;

    assign gx_pos = {2'b00, top_reg} + {1'b0, mid_reg, 1'b0} + {2'b00, v};
    assign gx_neg = {2'b00, win_reg[3]} + {1'b0, win_reg[4], 1'b0} + {2'b00, win_reg[5]};
    assign gy_pos = {2'b00, win_reg[5]} + {1'b0, win_reg[2], 1'b0} + {2'b00, v};
    assign gy_neg = {2'b00, win_reg[3]} + {1'b0, win_reg[0], 1'b0} + {2'b00, top_reg};

    assign produce = (state_reg == F_PROC) && (r_reg >= ROW_W'(2)) && (c_reg >= COL_W'(2));
    assign push    = produce;

    always_comb
    begin
        push_entry.row  = r_reg - ROW_W'(1);
        push_entry.col  = c_reg - COL_W'(1);
        push_entry.gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        push_entry.gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        push_entry.last = (r_reg == cfg.h_last) && (c_reg == cfg.w_last);
    end

    // line stores: read on accept, written back in the cycle after
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg <= upper_mem[col_reg];
            mid_reg <= middle_mem[col_reg];
        end
        if (state_reg == F_PROC)
        begin
            upper_mem[c_reg]  <= mid_reg;
            middle_mem[c_reg] <= v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= s_tdata;
            r_reg   <= row_reg;
            c_reg   <= col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (cfg.restart)
                    begin
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    else if (accept)
                    begin
                        state_reg <= F_PROC;
                        if (col_reg == cfg.w_last)
                        begin
                            col_reg <= '0;
                            row_reg <= (row_reg == cfg.h_last) ? '0 : row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_reg <= col_reg + COL_W'(1);
                        end
                    end
                end
                F_PROC:
                begin
                    state_reg  <= F_IDLE;
                    win_reg[3] <= win_reg[0];
                    win_reg[4] <= win_reg[1];
                    win_reg[5] <= win_reg[2];
                    win_reg[0] <= top_reg;
                    win_reg[1] <= mid_reg;
                    win_reg[2] <= v;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sgm_queue.sv
// ----------------------------------------------------------------------------
// sgm_queue
// short fifo of window results between front and back
// ----------------------------------------------------------------------------
`include "sobel_gradient_magnitude_assert.svh"

module sgm_queue
    import sgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sgm_entry_t push_entry,
    input  logic       pop,
    output sgm_entry_t head,
    output sgm_qstat_t qstat
);

    sgm_entry_t        store_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]     cnt_reg;

    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign head        = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (Q_AW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (Q_AW+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    `SGM_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !qstat.full)
    `SGM_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !qstat.empty)
    `SGM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= (Q_AW+1)'(Q_DEPTH))
    `SGM_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, !qstat.empty)

endmodule

// File: rtl/core/sgm_back.sv
// ----------------------------------------------------------------------------
// sgm_back
// squares, bit-serial integer square root and output register
// ----------------------------------------------------------------------------
module sgm_back
    import sgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sgm_qstat_t  qstat,
    input  sgm_entry_t  head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [11:0] out_row, [21:12] out_col, [32:22] grad_x,
                                   // [43:33] grad_y, [54:44] magnitude, [55] zero
    output logic        m_tlast
);

    typedef enum logic [2:0] {B_IDLE, B_SQUARE, B_SUM, B_ROOT, B_DONE} bstate_t;

    localparam int ITER_W = $clog2(SQRT_STEPS);
    localparam int REM_W  = MAG_W + 1;

    bstate_t              state_reg;
    sgm_entry_t           item_reg;
    logic [SQ_W-1:0]      gx2_reg, gy2_reg;
    logic [RAD_W-1:0]     x_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [MAG_W-1:0]     root_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic [55:0]          tdata_reg;
    logic                 tvalid_reg;
    logic                 tlast_reg;

    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [REM_W+1:0]     rem_sh;
    logic [REM_W+1:0]     trial;
    logic                 fits;
    logic                 out_load;

    assign pop      = (state_reg == B_IDLE) && !qstat.empty;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    assign gx_sq    = item_reg.gx * item_reg.gx;
    assign gy_sq    = item_reg.gy * item_reg.gy;
    assign rem_sh   = {rem_reg, x_reg[RAD_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign fits     = rem_sh >= trial;
    assign out_load = (state_reg == B_DONE) && (!tvalid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            tvalid_reg <= 1'b0;
            tlast_reg  <= 1'b0;
            tdata_reg  <= '0;
            gx2_reg    <= '0;
            gy2_reg    <= '0;
            x_reg      <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
            iter_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                tvalid_reg <= 1'b1;
                tlast_reg  <= item_reg.last;
                tdata_reg  <= {1'b0, root_reg, item_reg.gy, item_reg.gx,
                               item_reg.col, item_reg.row};
            end
            else if (tvalid_reg && m_tready)
            begin
                tvalid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= B_SQUARE;
                    end
                end
                B_SQUARE:
                begin
                    gx2_reg   <= gx_sq[SQ_W-1:0];
                    gy2_reg   <= gy_sq[SQ_W-1:0];
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    x_reg     <= RAD_W'(gx2_reg) + RAD_W'(gy2_reg);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= '0;
                    state_reg <= B_ROOT;
                end
                B_ROOT:
                begin
                    // one result bit per cycle, two radicand bits consumed
                    x_reg <= {x_reg[RAD_W-3:0], 2'b00};
                    if (fits)
                    begin
                        rem_reg  <= REM_W'(rem_sh - trial);
                        root_reg <= {root_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= REM_W'(rem_sh);
                        root_reg <= {root_reg[MAG_W-2:0], 1'b0};
                    end
                    if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        iter_reg <= iter_reg + ITER_W'(1);
                    end
                end
                B_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 sobel edge detector with exact integer gradient magnitude
// ----------------------------------------------------------------------------
// front: takes a new pixel only after the line store read and its write-back
// back: one interior result at a time, pops the next when done; 11-step square root unit
// a 4-entry queue lets the front run ahead over border pixels
// reset: asynchronous active low; width 640, height 480, frame starts at row 0
// line stores are not cleared; each frame fills them before use
module sobel_gradient_magnitude
    import sgm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] pixel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,    // [11:0] out_row, [21:12] out_col, [32:22] grad_x,
                                          // [43:33] grad_y, [54:44] magnitude, [55] zero
    output logic              m_tlast     // last
);

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic               wr;
    sgm_cfg_t           cfg;
    sgm_qstat_t         qstat;
    sgm_entry_t         push_entry, head;
    logic               push, pop;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp to the supported frame size
    always_comb
    begin
        if (width_reg < CFG_W_W'(MIN_DIM))
        begin
            cfg.w_last = COL_W'(MIN_DIM - 1);
        end
        else if (width_reg > CFG_W_W'(MAX_WIDTH))
        begin
            cfg.w_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            cfg.w_last = COL_W'(width_reg - CFG_W_W'(1));
        end
        if (height_reg < CFG_H_W'(MIN_DIM))
        begin
            cfg.h_last = ROW_W'(MIN_DIM - 1);
        end
        else if (height_reg > CFG_H_W'(MAX_HEIGHT))
        begin
            cfg.h_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            cfg.h_last = ROW_W'(height_reg - CFG_H_W'(1));
        end
        cfg.restart = wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_H_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    sgm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    sgm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    sgm_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb_sobel_gradient_magnitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_gradient_magnitude
// self-checking bench for the streaming sobel edge detector: pixels go in
// frame by frame under several image sizes, and an in-bench predictor of the
// line stores, window and square root checks every gradient item that
// comes out, with random gaps on the pixel side and random stalls on the
// result side
// ----------------------------------------------------------------------------
module tb_sobel_gradient_magnitude;
    import sgm_pkg::*;

    typedef enum int {PAT_NOISE, PAT_VSTEP, PAT_HSTEP, PAT_FLAT, PAT_CHECKER} pattern_t;
    typedef enum logic [1:0] {SINK_ALWAYS, SINK_HALF, SINK_SPARSE} sink_mode_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [MAG_W-1:0]  mag;
        logic              last;
    } gradient_t;

    localparam logic [APB_AW-1:0] ADDR_IMAGE_WIDTH  = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_IMAGE_HEIGHT = {REG_IMAGE_HEIGHT, 2'b00};
    localparam int               SETTLE_CYCLES     = 40;
    localparam int               HOLD_CYCLES       = 500;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [7:0] pixel
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;         // [11:0] out_row, [21:12] out_col, [32:22] grad_x,
                                        // [43:33] grad_y, [54:44] magnitude, [55] zero
    logic              m_tlast;

    sobel_gradient_magnitude u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic [7:0]         line_upper [MAX_WIDTH];
    logic [7:0]         line_middle [MAX_WIDTH];
    logic [7:0]         window [6];
    logic [CFG_W_W-1:0] cfg_width  = WIDTH_RESET;
    logic [CFG_H_W-1:0] cfg_height = HEIGHT_RESET;
    int unsigned        row_pos    = 0;
    int unsigned        col_pos    = 0;

    logic [7:0] pixel_queue [$];
    gradient_t  expected_gradients [$];

    bit          pix_handshake = 1'b0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    sink_mode_t  sink_mode     = SINK_ALWAYS;
    int          mode_left     = 0;
    int          hold_left     = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;

    int pixels_taken   = 0;
    int results_seen   = 0;
    int frame_ends     = 0;
    int reg_writes     = 0;
    int mismatches     = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d items outstanding", $time, expected_gradients.size());
        $display("sobel_gradient_magnitude verification failed");
        $finish;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] floor_sqrt(int unsigned sq);
        logic [MAG_W-1:0] root;
        int unsigned      trial;
        root = '0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    function automatic void predict_pixel(logic [7:0] pix);
        int unsigned w, h, r, c, sq;
        logic [7:0]  v, top, mid;
        int          gx, gy;
        gradient_t   res;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        if (col_pos >= w || row_pos >= h)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        v = pix;
        // outer ring of the frame counts as black
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
            v = '0;
        top = line_upper[c];
        mid = line_middle[c];
        line_upper[c]  = mid;
        line_middle[c] = v;
        if (r >= 2 && c >= 2)
        begin
            gx = (int'(top) + 2 * int'(mid) + int'(v))
               - (int'(window[3]) + 2 * int'(window[4]) + int'(window[5]));
            gy = (int'(window[5]) + 2 * int'(window[2]) + int'(v))
               - (int'(window[3]) + 2 * int'(window[0]) + int'(top));
            sq = gx * gx + gy * gy;
            res.row  = ROW_W'(r - 1);
            res.col  = COL_W'(c - 1);
            res.gx   = GRAD_W'(gx);
            res.gy   = GRAD_W'(gy);
            res.mag  = floor_sqrt(sq);
            res.last = (r == h - 1 && c == w - 1);
            expected_gradients.push_back(res);
        end
        window[3] = window[0];
        window[4] = window[1];
        window[5] = window[2];
        window[0] = top;
        window[1] = mid;
        window[2] = v;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // monitor and scoreboard
    always @(posedge clk)
    begin
        gradient_t want;
        if (rst_n)
        begin
            pix_handshake = s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_gradients.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got row %0d col %0d",
                             $time, m_tdata[11:0], m_tdata[21:12]);
                    mismatches++;
                end
                else
                begin
                    want = expected_gradients.pop_front();
                    compare_field("out_row", want.row, m_tdata[11:0]);
                    compare_field("out_col", want.col, m_tdata[21:12]);
                    compare_field("grad_x", $signed(want.gx), $signed(m_tdata[32:22]));
                    compare_field("grad_y", $signed(want.gy), $signed(m_tdata[43:33]));
                    compare_field("magnitude", want.mag, m_tdata[54:44]);
                    compare_field("padding", 0, m_tdata[55]);
                    compare_field("last", want.last, m_tlast);
                    if (want.last)
                        frame_ends++;
                end
                results_seen++;
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_IMAGE_HEIGHT)
                    cfg_height = pwdata[CFG_H_W-1:0];
                else
                    cfg_width = pwdata[CFG_W_W-1:0];
                row_pos = 0;
                col_pos = 0;
                reg_writes++;
            end
            if (pix_handshake)
            begin
                predict_pixel(s_tdata);
                pixels_taken++;
            end
        end
    end

    // pixel driver, bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || pix_handshake))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pixel_queue.size() > 0)
            begin
                s_tdata  <= pixel_queue.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result sink with its own stall pattern and long hold-offs on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                hold_left   <= HOLD_CYCLES;
                m_tready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    sink_mode <= sink_mode_t'($urandom_range(0, 2));
                    mode_left <= $urandom_range(16, 128);
                end
                else
                    mode_left <= mode_left - 1;
                case (sink_mode)
                    SINK_ALWAYS: m_tready <= 1'b1;
                    SINK_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    default:     m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || s_tvalid || expected_gradients.size() != 0)
            @(posedge clk);
        // border pixels may still be in flight with nothing expected
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_pixels(input int unsigned wv, input int unsigned hv, input int count,
                                input pattern_t pat, input logic [7:0] level);
        int unsigned w, h, r, c, split;
        logic [7:0]  pix;
        w = clamp_dim(wv, MAX_WIDTH);
        h = clamp_dim(hv, MAX_HEIGHT);
        split = (pat == PAT_HSTEP) ? $urandom_range(0, h - 1) : $urandom_range(0, w - 1);
        for (int k = 0; k < count; k++)
        begin
            c = k % w;
            r = (k / w) % h;
            case (pat)
                PAT_VSTEP:   pix = (c >= split) ? level : 8'd0;
                PAT_HSTEP:   pix = (r >= split) ? level : 8'd0;
                PAT_FLAT:    pix = level;
                PAT_CHECKER: pix = ((r + c) & 1) ? level : 8'd0;
                default:     pix = 8'($urandom_range(0, 255));
            endcase
            pixel_queue.push_back(pix);
        end
    endtask

    task automatic run_phase(input int unsigned wv, input int unsigned hv, input int count,
                             input pattern_t pat, input logic [7:0] level);
        wait_drained();
        apb_write(ADDR_IMAGE_WIDTH, wv);
        apb_write(ADDR_IMAGE_HEIGHT, hv);
        queue_pixels(wv, hv, count, pat, level);
    endtask

    initial
    begin
        int unsigned wv, hv, frame;
        int          count;
        int          random_pixels;
        pattern_t    pat;
        random_pixels = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_upper[i]  = '0;
            line_middle[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            window[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry, part of the first row only
        queue_pixels(WIDTH_RESET, HEIGHT_RESET, 20, PAT_NOISE, 8'd0);
        // smallest frame, all white
        run_phase(3, 3, 9, PAT_FLAT, 8'd255);
        // checkerboard for large gradients of both signs
        run_phase(5, 4, 20, PAT_CHECKER, 8'd255);
        run_phase(7, 5, 35, PAT_VSTEP, 8'd255);
        // widest frame, width register all ones and clamped
        run_phase(2047, 3, 120, PAT_NOISE, 8'd0);
        // height register all ones, then both at their top legal values
        run_phase(5, 8191, 60, PAT_HSTEP, 8'd255);
        run_phase(MAX_WIDTH, MAX_HEIGHT, 12, PAT_NOISE, 8'd0);

        // long hold-off on the result side while pixels keep coming
        run_phase(6, 20, 120, PAT_NOISE, 8'd0);
        hold_requests++;

        while (random_pixels < 330)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    wv = $urandom_range(0, 2);
                    hv = $urandom_range(3, 8);
                end
                1:
                begin
                    wv = $urandom_range(3, 10);
                    hv = $urandom_range(0, 2);
                end
                2:
                begin
                    wv = $urandom_range(3, 40);
                    hv = $urandom_range(3, 6);
                end
                default:
                begin
                    wv = $urandom_range(3, 12);
                    hv = $urandom_range(3, 10);
                end
            endcase
            frame = clamp_dim(wv, MAX_WIDTH) * clamp_dim(hv, MAX_HEIGHT);
            case ($urandom_range(0, 4))
                0:       count = $urandom_range(1, 2 * frame);
                1:       count = frame + $urandom_range(1, frame);
                2:       count = 2 * frame;
                default: count = frame;
            endcase
            pat = pattern_t'($urandom_range(0, 4));
            run_phase(wv, hv, count, pat, 8'($urandom_range(1, 255)));
            random_pixels += count;
        end

        wait_drained();
        if (expected_gradients.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, expected_gradients.size());
            mismatches++;
        end
        $display("covered %0d pixels and %0d gradient items, %0d of them frame ends",
                 pixels_taken, results_seen, frame_ends);
        $display("%0d register writes across clamped, minimum and maximum image sizes",
                 reg_writes);
        if (mismatches == 0)
            $display("sobel_gradient_magnitude verification clean");
        else
            $display("sobel_gradient_magnitude verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sgm_pkg.sv
rtl/core/sgm_front.sv
rtl/core/sgm_queue.sv
rtl/core/sgm_back.sv
rtl/core/sobel_gradient_magnitude.sv
tb/tb_sobel_gradient_magnitude.sv
